// ===== rtl/lnc_pkg.sv =====
// lnc_pkg: shared constants, register codes and control structs of the lms noise canceller
// used by every rtl file of the block but lnc_ram; no dependencies

package lnc_pkg;

  // default sizes
  localparam int TAPS_DEF        = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 24;

  // fixed formats
  localparam int STEP_BITS   = 16;  // mu, unsigned q0.16
  localparam int WEIGHT_INT  = 5;   // integer bits of a weight, sign included
  localparam int WEIGHT_MAX  = 10;  // weight clamp magnitude in integer units

  // apb register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_STEP_SIZE = 1'b0;

  // sequencer to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic issue;     // memory read issued this cycle
    logic upd;       // issued read belongs to the update pass
    logic load_err;  // capture the error and present it on the output
    logic load_me;   // form mu times error
  } lnc_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic busy;      // reads still in flight
    logic out_free;  // output register can take a new error
  } lnc_stat_t;

endpackage

// ===== rtl/lnc_stream_if.sv =====
// lnc_in_if / lnc_out_if: valid-ready channels of the lms noise canceller
// depends on lnc_pkg for the default sample width

interface lnc_in_if #(
  parameter int SAMPLE_BITS = lnc_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] primary_sample;
  logic signed [SAMPLE_BITS-1:0] reference_sample;

  modport source (output valid, output primary_sample, output reference_sample, input ready);
  modport sink   (input valid, input primary_sample, input reference_sample, output ready);
endinterface

interface lnc_out_if #(
  parameter int SAMPLE_BITS = lnc_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

// ===== rtl/lnc_ram.sv =====
// lnc_ram: generic memory, one write port and one read port, registered read data
// no dependencies

module lnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lnc_ctrl.sv =====
// lnc_ctrl: sequencer of the lms noise canceller; clearing pass, filter pass, update pass
// depends on lnc_pkg; drives the read addresses and the history write port

module lnc_ctrl #(
  parameter int TAPS        = lnc_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = lnc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   reference_sample_i,
  input  lnc_pkg::lnc_stat_t              stat_i,
  output lnc_pkg::lnc_ctrl_t              ctrl_o,
  output logic [$clog2(TAPS)-1:0]         w_raddr_o,
  output logic [$clog2(TAPS)-1:0]         h_raddr_o,
  output logic                            h_we_o,
  output logic [$clog2(TAPS)-1:0]         h_waddr_o,
  output logic signed [SAMPLE_BITS-1:0]   h_wdata_o,
  output logic                            clr_we_o,
  output logic [$clog2(TAPS)-1:0]         clr_addr_o
);

  localparam int IDX_W = $clog2(TAPS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FILT  = 7'b0000100,
    ST_EMIT  = 7'b0001000,
    ST_MU    = 7'b0010000,
    ST_UPD   = 7'b0100000,
    ST_DRAIN = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] hptr_q, hptr_d;
  logic [IDX_W-1:0] newest_q, newest_d;
  logic [IDX_W-1:0] newest_dec;
  logic [IDX_W-1:0] hptr_inc;
  lnc_pkg::lnc_ctrl_t ctl;

  assign newest_dec = (newest_q == '0) ? LAST : newest_q - 1'b1;
  assign hptr_inc   = (hptr_q == LAST) ? '0 : hptr_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    hptr_d   = hptr_q;
    newest_d = newest_q;
    ctl      = '0;
    case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl.accept = 1'b1;
          newest_d   = newest_dec;
          hptr_d     = newest_dec;
          idx_d      = '0;
          state_d    = ST_FILT;
        end
      end
      ST_FILT, ST_UPD: begin
        ctl.issue = 1'b1;
        ctl.upd   = (state_q == ST_UPD);
        idx_d     = idx_q + 1'b1;
        hptr_d    = hptr_inc;
        if (idx_q == LAST) begin
          idx_d   = '0;
          hptr_d  = newest_q;
          state_d = (state_q == ST_FILT) ? ST_EMIT : ST_DRAIN;
        end
      end
      ST_EMIT: begin
        if (!stat_i.busy && stat_i.out_free) begin
          ctl.load_err = 1'b1;
          state_d      = ST_MU;
        end
      end
      ST_MU: begin
        ctl.load_me = 1'b1;
        state_d     = ST_UPD;
      end
      ST_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      idx_q    <= '0;
      hptr_q   <= '0;
      newest_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      hptr_q   <= hptr_d;
      newest_q <= newest_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign ctrl_o     = ctl;
  assign w_raddr_o  = idx_q;
  assign h_raddr_o  = hptr_q;

  assign clr_we_o   = (state_q == ST_CLEAR);
  assign clr_addr_o = idx_q;

  // new reference lands in its slot at the accepting edge
  assign h_we_o    = clr_we_o || ctl.accept;
  assign h_waddr_o = clr_we_o ? idx_q : newest_dec;
  assign h_wdata_o = clr_we_o ? '0 : reference_sample_i;

`ifndef SYNTHESIS
  a_accept_starts_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.accept |=> (state_q == ST_FILT) && (idx_q == '0) && (hptr_q == newest_q))
    else $error("filter pass did not start at the newest reference");
`endif

endmodule

// ===== rtl/lnc_datapath.sv =====
// lnc_datapath: shared multiplier, accumulator, error rounding and weight update
// depends on lnc_pkg; fed by the two memories and the sequencer

module lnc_datapath #(
  parameter int TAPS        = lnc_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = lnc_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = lnc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lnc_pkg::lnc_ctrl_t                   ctrl_i,
  output lnc_pkg::lnc_stat_t                   stat_o,
  input  logic [$clog2(TAPS)-1:0]              w_raddr_i,
  input  logic [lnc_pkg::STEP_BITS-1:0]        step_size_i,
  input  logic signed [SAMPLE_BITS-1:0]        primary_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]        h_rdata_i,
  input  logic signed [WEIGHT_BITS-1:0]        w_rdata_i,
  output logic                                 w_we_o,
  output logic [$clog2(TAPS)-1:0]              w_waddr_o,
  output logic signed [WEIGHT_BITS-1:0]        w_wdata_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        error_sample_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int WB    = WEIGHT_BITS;
  localparam int IDX_W = $clog2(TAPS);
  localparam int WF    = WB - lnc_pkg::WEIGHT_INT;
  localparam int ACC_W = WB + SB + IDX_W + 1;
  localparam int EST_W = ACC_W - WF;
  localparam int DIF_W = EST_W + 1;
  localparam int ME_W  = lnc_pkg::STEP_BITS + 1 + SB;
  localparam int PU_W  = ME_W + SB;
  localparam int US    = lnc_pkg::STEP_BITS + 2 * (SB - 1) - 1 - WF;
  localparam int DEL_W = PU_W + 1 - US;
  localparam int SUM_W = ((WB > DEL_W) ? WB : DEL_W) + 1;
  localparam int MA_W  = (WB > ME_W) ? WB : ME_W;
  localparam int MP_W  = MA_W + SB;

  localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(1) << (WF - 1);
  localparam logic signed [PU_W:0]    HALF_U = (PU_W + 1)'(1) << (US - 1);
  localparam logic signed [DIF_W-1:0] SMAX   = DIF_W'((longint'(1) << (SB - 1)) - 1);
  localparam logic signed [DIF_W-1:0] SMIN   = DIF_W'(-(longint'(1) << (SB - 1)));
  localparam logic signed [SUM_W-1:0] WLIM   =
    SUM_W'(longint'(lnc_pkg::WEIGHT_MAX) << WF);
  localparam logic signed [SUM_W-1:0] WLIM_N =
    SUM_W'(-(longint'(lnc_pkg::WEIGHT_MAX) << WF));

  logic                    s1_v_q, s2_v_q;
  logic                    s1_upd_q, s2_upd_q;
  logic [IDX_W-1:0]        s1_addr_q, s2_addr_q;
  logic signed [MP_W-1:0]  prod_q;
  logic signed [WB-1:0]    w_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SB-1:0]    prim_q;
  logic signed [SB-1:0]    err_q;
  logic signed [ME_W-1:0]  me_q;
  logic                    out_valid_q;
  logic signed [SB-1:0]    out_data_q;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MP_W-1:0]  mul_p;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [EST_W-1:0] est;
  logic signed [DIF_W-1:0] diff;
  logic signed [SB-1:0]    err_c;
  logic signed [PU_W:0]    upd_rnd;
  logic signed [DEL_W-1:0] delta;
  logic signed [SUM_W-1:0] wsum;

  // one multiplier: weight times reference, or mu*error times reference
  assign mul_a = s1_upd_q ? MA_W'(me_q) : MA_W'(w_rdata_i);
  assign mul_p = mul_a * h_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q <= ctrl_i.issue;
      s2_v_q <= s1_v_q;
      if (ctrl_i.load_err) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_upd_q  <= ctrl_i.upd;
    s1_addr_q <= w_raddr_i;
    s2_upd_q  <= s1_upd_q;
    s2_addr_q <= s1_addr_q;
    prod_q    <= mul_p;
    w_q       <= w_rdata_i;
    if (ctrl_i.accept) begin
      prim_q <= primary_sample_i;
      acc_q  <= '0;
    end else if (s2_v_q && !s2_upd_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctrl_i.load_err) begin
      err_q      <= err_c;
      out_data_q <= err_c;
    end
    if (ctrl_i.load_me) begin
      me_q <= $signed({1'b0, step_size_i}) * err_q;
    end
  end

  // estimate rounded half up, then primary minus estimate saturated
  always_comb begin
    acc_rnd = acc_q + HALF_F;
    est     = acc_rnd[ACC_W-1:WF];
    diff    = DIF_W'(prim_q) - DIF_W'(est);
    if (diff > SMAX) begin
      err_c = SMAX[SB-1:0];
    end else if (diff < SMIN) begin
      err_c = SMIN[SB-1:0];
    end else begin
      err_c = diff[SB-1:0];
    end
  end

  // delta rounded half up into weight units, then clamp to the weight limit
  always_comb begin
    upd_rnd = (PU_W + 1)'(prod_q) + HALF_U;
    delta   = upd_rnd[PU_W:US];
    wsum    = SUM_W'(w_q) + SUM_W'(delta);
    if (wsum > WLIM) begin
      w_wdata_o = WLIM[WB-1:0];
    end else if (wsum < WLIM_N) begin
      w_wdata_o = WLIM_N[WB-1:0];
    end else begin
      w_wdata_o = wsum[WB-1:0];
    end
  end

  assign w_we_o    = s2_v_q && s2_upd_q;
  assign w_waddr_o = s2_addr_q;

  assign stat_o.busy     = s1_v_q || s2_v_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign error_sample_o = out_data_q;

`ifndef SYNTHESIS
  a_err_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load_err |-> !s1_v_q && !s2_v_q && !ctrl_i.issue)
    else $error("error formed before the filter sum was complete");

  a_weight_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_we_o |-> (SUM_W'(w_wdata_o) <= WLIM) && (SUM_W'(w_wdata_o) >= WLIM_N))
    else $error("weight written outside the clamp range");
`endif

endmodule

// ===== rtl/lms_noise_canceller_unit.sv =====
// lms_noise_canceller_unit: top level of the adaptive lms noise canceller
// depends on lnc_pkg, lnc_stream_if, lnc_ram, lnc_ctrl and lnc_datapath
//
//   channel   dir   handshake          payload
//   in_i      in    valid / ready      primary_sample, reference_sample
//   out_o     out   valid / ready      error_sample
//   apb       in    psel / penable     paddr, pwdata, pwrite; prdata, pready out
//
// no new item is taken until the last one is through: each pass walks the taps through
// the single read port of the history and weight memories, filter then update
// error_sample is loaded once the filter pass has drained and the output register is free
// after reset a clearing pass zeroes both memories, input held off
// a waiting output holds the sequencer before the update pass; the apb port never stalls

module lms_noise_canceller_unit #(
  parameter int TAPS        = lnc_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = lnc_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = lnc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lnc_in_if.sink                           in_i,
  lnc_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lnc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lnc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lnc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int IDX_W = $clog2(TAPS);

  logic [lnc_pkg::STEP_BITS-1:0] step_q;
  logic                          step_sel;

  lnc_pkg::lnc_ctrl_t ctl;
  lnc_pkg::lnc_stat_t stat;

  logic [IDX_W-1:0]              w_raddr, h_raddr, h_waddr, clr_addr, dp_waddr, w_waddr;
  logic                          h_we, clr_we, dp_we, w_we;
  logic signed [SAMPLE_BITS-1:0] h_wdata, h_rdata;
  logic signed [WEIGHT_BITS-1:0] dp_wdata, w_wdata, w_rdata;

  // configuration register
  assign step_sel = (paddr[lnc_pkg::APB_ADDR_W-1] == lnc_pkg::REG_STEP_SIZE);
  assign pready   = 1'b1;
  assign prdata   = step_sel ? lnc_pkg::APB_DATA_W'(step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (psel && penable && pwrite && step_sel) begin
      step_q <= pwdata[lnc_pkg::STEP_BITS-1:0];
    end
  end

  lnc_ctrl #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_i.valid),
    .in_ready_o         (in_i.ready),
    .reference_sample_i (in_i.reference_sample),
    .stat_i             (stat),
    .ctrl_o             (ctl),
    .w_raddr_o          (w_raddr),
    .h_raddr_o          (h_raddr),
    .h_we_o             (h_we),
    .h_waddr_o          (h_waddr),
    .h_wdata_o          (h_wdata),
    .clr_we_o           (clr_we),
    .clr_addr_o         (clr_addr)
  );

  lnc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // weight memory: zeroed by the clearing pass, rewritten by the update pass
  assign w_we    = clr_we || dp_we;
  assign w_waddr = clr_we ? clr_addr : dp_waddr;
  assign w_wdata = clr_we ? '0 : dp_wdata;

  lnc_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (TAPS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  lnc_datapath #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctl),
    .stat_o           (stat),
    .w_raddr_i        (w_raddr),
    .step_size_i      (step_q),
    .primary_sample_i (in_i.primary_sample),
    .h_rdata_i        (h_rdata),
    .w_rdata_i        (w_rdata),
    .w_we_o           (dp_we),
    .w_waddr_o        (dp_waddr),
    .w_wdata_o        (dp_wdata),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .error_sample_o   (out_o.error_sample)
  );

`ifndef SYNTHESIS
  a_no_update_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_we |-> !dp_we && !in_i.ready)
    else $error("weight update or input transaction during the clearing pass");
`endif

endmodule
